@@ hdl/smvm_pkg.sv @@
// shared types and constants of the sparse matrix-vector multiply unit
package smvm_pkg;

   // x vector store and row counting
   localparam int VECTOR_DEPTH = 1024;
   localparam int X_ADDR_W     = $clog2(VECTOR_DEPTH);
   localparam int MAX_ROWS     = 1024;
   localparam int ROW_W        = 10;
   localparam int ROW_LIMIT_W  = 11;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // widths
   localparam int DATA_W = 32;
   localparam int SUM_W  = 48;
   localparam int PROD_W = 64;

   // action codes of an input beat
   localparam logic [1:0] ACT_LOAD    = 2'd0;
   localparam logic [1:0] ACT_NONZERO = 2'd1;
   localparam logic [1:0] ACT_ROW_END = 2'd2;

   // register indexes of the csr port
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BETA  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS  = 2'd2;

   // register reset values
   localparam logic signed [DATA_W-1:0]   ALPHA_RESET = 32'sh0001_0000;
   localparam logic signed [DATA_W-1:0]   BETA_RESET  = 32'sh0000_0000;
   localparam logic [ROW_LIMIT_W-1:0]     ROWS_RESET  = 11'd1024;

   // input beat
   typedef struct packed {
      logic [1:0]               action;
      logic [9:0]               index;
      logic signed [DATA_W-1:0] value;
      logic                     row_end;
      logic signed [DATA_W-1:0] y_value;
   } req_type;

   // result beat
   typedef struct packed {
      logic [ROW_W-1:0]         row_index;
      logic signed [DATA_W-1:0] z_value;
      logic                     saturated;
   } rsp_type;

   // classified work item from front to back
   typedef struct packed {
      logic                     is_nonzero;
      logic                     row_end;
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] x_value;
      logic signed [DATA_W-1:0] y_value;
   } work_type;

endpackage

@@ hdl/smvm_queue.sv @@
// short work queue between the front and the back engine
module smvm_queue import smvm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_en,
   input  work_type wr_item,
   output logic     full,
   input  logic     rd_en,
   output work_type rd_item,
   output logic     empty
);

   work_type                 entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]     count_ff, count_in;
   logic                     do_wr, do_rd;

   // status and pointer update
   always_comb begin
      full    = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
      empty   = (count_ff == '0);
      do_wr   = wr_en && !full;
      do_rd   = rd_en && !empty;
      rd_item = entries_ff[rd_ptr_ff];
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         entries_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

@@ hdl/smvm_front.sv @@
// front end: accepts beats, keeps the x vector store and classifies work
module smvm_front import smvm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   output logic     full,
   input  req_type  req_data,
   output logic     q_push,
   output work_type q_item,
   input  logic     q_full
);

   logic signed [DATA_W-1:0] x_mem_ff [VECTOR_DEPTH];
   logic signed [DATA_W-1:0] x_rd_ff;
   work_type                 stage_ff, stage_in;
   logic                     stage_valid_ff, stage_valid_in;
   logic                     advance, accept, is_work;
   logic [X_ADDR_W-1:0]      addr;

   // accept and classify
   always_comb begin
      advance = !stage_valid_ff || !q_full;
      full    = !advance;
      accept  = push && advance;
      is_work = req_data.action inside {ACT_NONZERO, ACT_ROW_END};
      addr    = req_data.index[X_ADDR_W-1:0];

      stage_valid_in = advance ? (accept && is_work) : stage_valid_ff;
      stage_in       = stage_ff;
      if (accept && is_work) begin
         stage_in.is_nonzero = (req_data.action == ACT_NONZERO);
         stage_in.row_end    = req_data.row_end;
         stage_in.value      = req_data.value;
         stage_in.x_value    = '0;
         stage_in.y_value    = req_data.y_value;
      end

      q_push         = stage_valid_ff;
      q_item         = stage_ff;
      q_item.x_value = x_rd_ff;
   end

   // stage valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   // x vector store: write on load, registered read on nonzero
   always_ff @(posedge clock) begin
      if (accept && req_data.action == ACT_LOAD) begin
         x_mem_ff[addr] <= req_data.value;
      end
      if (accept && req_data.action == ACT_NONZERO) begin
         x_rd_ff <= x_mem_ff[addr];
      end
   end

endmodule

@@ hdl/smvm_back.sv @@
// back engine: scaled products, row accumulation and the result register
module smvm_back import smvm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_empty,
   input  work_type                 q_item,
   output logic                     q_pop,
   input  logic signed [DATA_W-1:0] alpha,
   input  logic signed [DATA_W-1:0] beta,
   input  logic [ROW_LIMIT_W-1:0]   rows_in_use,
   input  logic                     pop,
   output logic                     empty,
   output rsp_type                  rsp_data
);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_MUL_P  = 9'b000000010,
      ST_MUL_HI = 9'b000000100,
      ST_MUL_LO = 9'b000001000,
      ST_TERM   = 9'b000010000,
      ST_ACC    = 9'b000100000,
      ST_BETA   = 9'b001000000,
      ST_BADD   = 9'b010000000,
      ST_EMIT   = 9'b100000000
   } state_type;

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   state_type                state_ff, state_in;
   work_type                 work_ff, work_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [PROD_W-1:0] hi_ff, hi_in;
   logic [15:0]              lo_ff, lo_in;
   logic signed [SUM_W-1:0]  term_ff, term_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [ROW_W-1:0]         row_ff, row_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic signed [DATA_W:0]   mul_a, mul_b;
   logic signed [2*DATA_W+1:0] mul_p;
   logic signed [PROD_W-1:0] term_wide;
   logic [ROW_LIMIT_W-1:0]   limit, row_next;
   logic                     z_sat;
   logic signed [DATA_W-1:0] z_clip;

   // saturating 48-bit add
   function automatic logic signed [SUM_W-1:0] sat_add48(
      input logic signed [SUM_W-1:0] a,
      input logic signed [SUM_W-1:0] b
   );
      logic signed [SUM_W:0] s;
      s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
      if (s[SUM_W] != s[SUM_W-1]) begin
         return s[SUM_W] ? SUM_MIN : SUM_MAX;
      end
      return s[SUM_W-1:0];
   endfunction

   // shared multiplier operand selection
   always_comb begin
      case (state_ff)
         ST_MUL_P: begin
            mul_a = $signed({work_ff.value[DATA_W-1], work_ff.value});
            mul_b = $signed({work_ff.x_value[DATA_W-1], work_ff.x_value});
         end
         ST_MUL_HI: begin
            mul_a = $signed({prod_ff[PROD_W-1], prod_ff[PROD_W-1:DATA_W]});
            mul_b = $signed({alpha[DATA_W-1], alpha});
         end
         ST_MUL_LO: begin
            mul_a = $signed({17'd0, lo_ff});
            mul_b = $signed({alpha[DATA_W-1], alpha});
         end
         ST_BETA: begin
            mul_a = $signed({beta[DATA_W-1], beta});
            mul_b = $signed({work_ff.y_value[DATA_W-1], work_ff.y_value});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   // product term with the low half folded in, clipped to 48 bits
   always_comb begin
      term_wide = hi_ff + {{16{prod_ff[PROD_W-1]}}, prod_ff[PROD_W-1:16]};
      if (term_wide[PROD_W-1:SUM_W-1] != '0 && term_wide[PROD_W-1:SUM_W-1] != '1) begin
         term_in = term_wide[PROD_W-1] ? SUM_MIN : SUM_MAX;
      end else begin
         term_in = term_wide[SUM_W-1:0];
      end
   end

   // row limit, next row and 32-bit clipping of the sum
   always_comb begin
      if (rows_in_use == '0) begin
         limit = ROW_LIMIT_W'(1);
      end else if (rows_in_use > ROW_LIMIT_W'(MAX_ROWS)) begin
         limit = ROW_LIMIT_W'(MAX_ROWS);
      end else begin
         limit = rows_in_use;
      end
      row_next = {1'b0, row_ff} + 1'b1;
      z_sat    = (sum_ff[SUM_W-1:DATA_W-1] != '0) && (sum_ff[SUM_W-1:DATA_W-1] != '1);
      if (z_sat) begin
         z_clip = sum_ff[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
         z_clip = sum_ff[DATA_W-1:0];
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      work_in      = work_ff;
      prod_in      = mul_p[PROD_W-1:0];
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      sum_in       = sum_ff;
      row_in       = row_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !pop;
      q_pop        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               work_in  = q_item;
               state_in = q_item.is_nonzero ? ST_MUL_P : ST_BETA;
            end
         end
         ST_MUL_P: begin
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            lo_in    = prod_ff[DATA_W-1:16];
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            hi_in    = prod_ff;
            state_in = ST_TERM;
         end
         ST_TERM: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            sum_in   = sat_add48(sum_ff, term_ff);
            state_in = work_ff.row_end ? ST_BETA : ST_IDLE;
         end
         ST_BETA: begin
            state_in = (beta != '0) ? ST_BADD : ST_EMIT;
         end
         ST_BADD: begin
            sum_in   = sat_add48(sum_ff, prod_ff[PROD_W-1:16]);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || pop) begin
               rsp_in.row_index = row_ff;
               rsp_in.z_value   = z_clip;
               rsp_in.saturated = z_sat;
               rsp_valid_in     = 1'b1;
               sum_in           = '0;
               row_in           = (row_next >= limit) ? '0 : row_next[ROW_W-1:0];
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      empty    = !rsp_valid_ff;
      rsp_data = rsp_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      work_ff <= work_in;
      prod_ff <= prod_in;
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
      term_ff <= term_in;
      rsp_ff  <= rsp_in;
   end

endmodule

@@ hdl/sparse_matrix_vector_multiply_csr_unit.sv @@
// Top level of the sparse matrix-vector multiply unit, z = alpha*A*x + beta*y.
// Loads take one beat a cycle while full is low; a nonzero or row end passes the front stage
// register, held there while the queue is full. One shared 33x33 multiplier: the back engine
// steps a nonzero through MUL_P, MUL_HI, MUL_LO, TERM and ACC, and a row end through BETA,
// BADD (only when beta is nonzero) and EMIT. Synchronous reset clears control state, row sum and
// counter; alpha 1.0, beta 0, rows 1024. The x store has no reset and holds junk until loaded.
module sparse_matrix_vector_multiply_csr_unit import smvm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  req_type                req_data,
   output logic                   empty,
   input  logic                   pop,
   output rsp_type                rsp_data,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]      csr_wdata
);

   logic signed [DATA_W-1:0] alpha_ff, alpha_in;
   logic signed [DATA_W-1:0] beta_ff, beta_in;
   logic [ROW_LIMIT_W-1:0]   rows_ff, rows_in;
   logic                     q_push, q_full, q_pop, q_empty;
   work_type                 q_wr_item, q_rd_item;

   // csr write decode
   always_comb begin
      alpha_in = alpha_ff;
      beta_in  = beta_ff;
      rows_in  = rows_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_ALPHA: alpha_in = $signed(csr_wdata);
            CSR_BETA:  beta_in  = $signed(csr_wdata);
            CSR_ROWS:  rows_in  = csr_wdata[ROW_LIMIT_W-1:0];
            default:   rows_in  = rows_ff;
         endcase
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_RESET;
         beta_ff  <= BETA_RESET;
         rows_ff  <= ROWS_RESET;
      end else begin
         alpha_ff <= alpha_in;
         beta_ff  <= beta_in;
         rows_ff  <= rows_in;
      end
   end

   // front end
   smvm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .q_push   (q_push),
      .q_item   (q_wr_item),
      .q_full   (q_full)
   );

   // work queue
   smvm_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_item (q_wr_item),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_item (q_rd_item),
      .empty   (q_empty)
   );

   // back engine
   smvm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_item      (q_rd_item),
      .q_pop       (q_pop),
      .alpha       (alpha_ff),
      .beta        (beta_ff),
      .rows_in_use (rows_ff),
      .pop         (pop),
      .empty       (empty),
      .rsp_data    (rsp_data)
   );

endmodule
